// ----- design/fhp_pkg.sv -----
// Package for the linear element Hessian projection block.
// Holds widths, memory geometry, the sequencer state type and rounding helpers.
// No dependencies; used by fem_element_hessian_projection.
package fhp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_DIM   = 3;
    localparam int NCOL      = MAX_DIM * MAX_DIM;
    localparam int NROW      = MAX_DIM * (MAX_DIM + 1);

    localparam int VAL_W  = 32;
    localparam int PP_W   = 48;
    localparam int ACC_W  = VAL_W + PP_W + 4;
    localparam int LO_W   = PP_W / 2;
    localparam int PROD_W = VAL_W + LO_W + 1;

    localparam int PP_DEPTH = NROW * NCOL;
    localparam int PP_AW    = $clog2(PP_DEPTH);
    localparam int IB_AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int IB_W     = MAX_DIM * VAL_W;
    localparam int DIM_W    = $clog2(MAX_DIM + 1);
    localparam int IDX_W    = 4;
    localparam int VSEL_W   = $clog2(NCOL);
    localparam int HROW_W   = $clog2(NROW);
    localparam int HALF_N   = 6;
    localparam int NVAL     = 9;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MH,
        S_ML,
        S_AC,
        S_WR,
        S_WT,
        S_OUT,
        S_IBW
    } t_state;

    // Adds half an LSB and shifts out the fraction (round half up).
    function automatic logic signed [ACC_W:0] round_fix(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W:0] t;
        t = {a[ACC_W-1], a};
        t = t + ((ACC_W + 1)'(1) << (FRAC_BITS - 1));
        t = t >>> FRAC_BITS;
        return t;
    endfunction

    function automatic logic signed [PP_W-1:0] sat_pp(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W:0] t;
        t = round_fix(a);
        if (t[ACC_W:PP_W-1] == '0 || t[ACC_W:PP_W-1] == '1) begin
            return t[PP_W-1:0];
        end else if (t[ACC_W]) begin
            return {1'b1, {(PP_W - 1){1'b0}}};
        end else begin
            return {1'b0, {(PP_W - 1){1'b1}}};
        end
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W:0] t;
        t = round_fix(a);
        if (t[ACC_W:VAL_W-1] == '0 || t[ACC_W:VAL_W-1] == '1) begin
            return t[VAL_W-1:0];
        end else if (t[ACC_W]) begin
            return {1'b1, {(VAL_W - 1){1'b0}}};
        end else begin
            return {1'b0, {(VAL_W - 1){1'b1}}};
        end
    endfunction

endpackage

// ----- design/fhp_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module fhp_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 4,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/fem_element_hessian_projection.sv -----
// Top level of the linear element Hessian projection (H = D^T A D).
// Depends on fhp_pkg and fhp_ram.
//
// Usage. The input channel takes one item per transfer. A mode-0 item reads
// the stored inverse rest row in its transfer cycle and writes it back merged
// in the next cycle, with the input stalled, so a 2D row keeps its third entry.
// A mode-1 item loads one column of the energy Hessian over F; the block then
// forms D^T times that column and writes it to the partial product memory. When
// the last column of the element has been loaded, the block emits the nodal
// Hessian as half-rows of six saturated Q16.16 values: 24 transfers in 3D,
// 6 in 2D, with last set on the final one.
// Datapath. All arithmetic goes through one shared 32 x 25 bit multiplier;
// every product runs through an upper-half, a lower-half and an accumulate
// step. A column load runs all of its products before the next item is
// accepted. Each output row runs the same products again, then loads each
// half-row into the output register and waits for its output transfer.
// Input stall is high whenever the sequencer is busy, including while a
// half-row waits on a stalled receiver; the held output does not change.
// Reset returns the sequencer to idle, drops output valid and sets three_dim but
// leaves the memories; the configuration register is written on its enable.
module fem_element_hessian_projection (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [3:0]  i_index,
    input  logic [31:0] i_value_0,
    input  logic [31:0] i_value_1,
    input  logic [31:0] i_value_2,
    input  logic [31:0] i_value_3,
    input  logic [31:0] i_value_4,
    input  logic [31:0] i_value_5,
    input  logic [31:0] i_value_6,
    input  logic [31:0] i_value_7,
    input  logic [31:0] i_value_8,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_row,
    output logic        o_half,
    output logic [31:0] o_out_0,
    output logic [31:0] o_out_1,
    output logic [31:0] o_out_2,
    output logic [31:0] o_out_3,
    output logic [31:0] o_out_4,
    output logic [31:0] o_out_5,
    output logic        o_last
);

    // Sequencer state and loop counters.
    fhp_pkg::t_state r_state, n_state;
    logic                           r_three_dim;
    logic                           r_emit, n_emit;
    logic [fhp_pkg::DIM_W-1:0]      r_i, n_i, r_a, n_a, r_j, n_j;
    logic [fhp_pkg::HROW_W-1:0]     r_r, n_r;
    logic [fhp_pkg::VSEL_W-1:0]     r_c, n_c;
    logic                           r_half, n_half;

    // Datapath registers.
    logic signed [fhp_pkg::VAL_W-1:0]  r_v [fhp_pkg::NCOL];
    logic signed [fhp_pkg::VAL_W-1:0]  n_v [fhp_pkg::NCOL];
    logic signed [fhp_pkg::PROD_W-1:0] r_prod, n_prod;
    logic signed [fhp_pkg::ACC_W-1:0]  r_acc, n_acc, r_total, n_total;
    logic signed [fhp_pkg::VAL_W-1:0]  r_hrow [fhp_pkg::NROW];
    logic signed [fhp_pkg::VAL_W-1:0]  n_hrow [fhp_pkg::NROW];

    // Output register.
    logic                           r_out_valid, n_out_valid;
    logic [fhp_pkg::HROW_W-1:0]     r_out_row, n_out_row;
    logic                           r_out_half, n_out_half;
    logic                           r_out_last, n_out_last;
    logic [fhp_pkg::VAL_W-1:0]      r_out [fhp_pkg::HALF_N];
    logic [fhp_pkg::VAL_W-1:0]      n_out [fhp_pkg::HALF_N];

    // Memory ports.
    logic                           ib_we;
    logic [fhp_pkg::IB_AW-1:0]      ib_waddr, ib_raddr;
    logic [fhp_pkg::IB_W-1:0]       ib_wdata, ib_rdata;
    logic                           pp_we;
    logic [fhp_pkg::PP_AW-1:0]      pp_waddr, pp_raddr;
    logic [fhp_pkg::PP_W-1:0]       pp_wdata, pp_rdata;

    // Combinational helpers.
    logic [fhp_pkg::VAL_W-1:0]         w_vals [fhp_pkg::NVAL];
    logic [fhp_pkg::DIM_W-1:0]         w_d;
    logic [fhp_pkg::HROW_W-1:0]        w_n;
    logic                              w_two_halves;
    logic                              in_accept;
    logic                              row_ok, col_ok;
    logic signed [fhp_pkg::VAL_W-1:0]  ib_word;
    logic signed [fhp_pkg::PP_W-1:0]   x_op;
    logic signed [fhp_pkg::LO_W:0]     x_part;
    logic signed [fhp_pkg::PROD_W-1:0] w_mul;
    logic [fhp_pkg::VSEL_W-1:0]        vsel;
    logic [fhp_pkg::HROW_W-1:0]        hidx;
    logic signed [fhp_pkg::ACC_W-1:0]  w_neg_total;

    assign w_vals[0] = i_value_0;
    assign w_vals[1] = i_value_1;
    assign w_vals[2] = i_value_2;
    assign w_vals[3] = i_value_3;
    assign w_vals[4] = i_value_4;
    assign w_vals[5] = i_value_5;
    assign w_vals[6] = i_value_6;
    assign w_vals[7] = i_value_7;
    assign w_vals[8] = i_value_8;

    assign w_d = (r_three_dim && fhp_pkg::MAX_DIM >= 3) ? fhp_pkg::DIM_W'(3)
                                                        : fhp_pkg::DIM_W'(2);
    assign w_n = fhp_pkg::HROW_W'(w_d) * (fhp_pkg::HROW_W'(w_d) + fhp_pkg::HROW_W'(1));
    assign w_two_halves = (w_n > fhp_pkg::HROW_W'(fhp_pkg::HALF_N));

    assign o_in_stall = (r_state != fhp_pkg::S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign row_ok     = (i_index < fhp_pkg::IDX_W'(w_d));
    assign col_ok     = (i_index < fhp_pkg::IDX_W'(w_d) * fhp_pkg::IDX_W'(w_d));

    // Inverse rest rows are written back in the cycle after the transfer. Entries
    // beyond the current dimension keep the stored value just read.
    assign ib_we    = (r_state == fhp_pkg::S_IBW);
    assign ib_waddr = fhp_pkg::IB_AW'(r_c);
    always_comb begin
        for (int k = 0; k < fhp_pkg::MAX_DIM; k++) begin
            if (fhp_pkg::DIM_W'(k) < w_d) begin
                ib_wdata[k*fhp_pkg::VAL_W +: fhp_pkg::VAL_W] = r_v[k];
            end else begin
                ib_wdata[k*fhp_pkg::VAL_W +: fhp_pkg::VAL_W] =
                    ib_rdata[k*fhp_pkg::VAL_W +: fhp_pkg::VAL_W];
            end
        end
    end

    // Read addresses follow the next-state counters so that the data is
    // ready in the first multiply cycle of each product.
    assign ib_raddr = fhp_pkg::IB_AW'(n_a - fhp_pkg::DIM_W'(1));
    assign pp_raddr = fhp_pkg::PP_AW'(n_r) * fhp_pkg::PP_AW'(fhp_pkg::NCOL)
                    + fhp_pkg::PP_AW'(n_i)
                    + fhp_pkg::PP_AW'(w_d) * fhp_pkg::PP_AW'(n_j);

    // Shared multiplier: the 48-bit operand is taken in two halves.
    assign ib_word = ib_rdata[r_j*fhp_pkg::VAL_W +: fhp_pkg::VAL_W];
    assign vsel    = fhp_pkg::VSEL_W'(r_i)
                   + fhp_pkg::VSEL_W'(w_d) * fhp_pkg::VSEL_W'(r_j);
    assign x_op    = r_emit ? pp_rdata : fhp_pkg::PP_W'(r_v[vsel]);
    assign x_part  = (r_state == fhp_pkg::S_MH)
                   ? {x_op[fhp_pkg::PP_W-1], x_op[fhp_pkg::PP_W-1:fhp_pkg::LO_W]}
                   : {1'b0, x_op[fhp_pkg::LO_W-1:0]};
    assign w_mul   = ib_word * x_part;

    assign hidx        = fhp_pkg::HROW_W'(w_d) * fhp_pkg::HROW_W'(r_a)
                       + fhp_pkg::HROW_W'(r_i);
    assign w_neg_total = -r_total;

    always_comb begin
        n_state     = r_state;
        n_emit      = r_emit;
        n_i         = r_i;
        n_a         = r_a;
        n_j         = r_j;
        n_r         = r_r;
        n_c         = r_c;
        n_half      = r_half;
        n_v         = r_v;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_total     = r_total;
        n_hrow      = r_hrow;
        n_out_valid = r_out_valid;
        n_out_row   = r_out_row;
        n_out_half  = r_out_half;
        n_out_last  = r_out_last;
        n_out       = r_out;
        pp_we       = 1'b0;
        pp_waddr    = fhp_pkg::PP_AW'(fhp_pkg::HROW_W'(hidx)) * fhp_pkg::PP_AW'(fhp_pkg::NCOL)
                    + fhp_pkg::PP_AW'(r_c);
        pp_wdata    = fhp_pkg::sat_pp(r_acc);

        case (r_state)
            fhp_pkg::S_IDLE: begin
                if (in_accept && i_mode && col_ok) begin
                    n_c     = fhp_pkg::VSEL_W'(i_index);
                    for (int k = 0; k < fhp_pkg::NCOL; k++) begin
                        n_v[k] = w_vals[k];
                    end
                    n_emit  = 1'b0;
                    n_i     = '0;
                    n_a     = fhp_pkg::DIM_W'(1);
                    n_j     = '0;
                    n_r     = '0;
                    n_acc   = '0;
                    n_total = '0;
                    n_state = fhp_pkg::S_MH;
                end else if (in_accept && !i_mode && row_ok) begin
                    // Read the stored row now; it is merged and written next cycle.
                    n_c     = fhp_pkg::VSEL_W'(i_index);
                    for (int k = 0; k < fhp_pkg::NCOL; k++) begin
                        n_v[k] = w_vals[k];
                    end
                    n_a     = fhp_pkg::DIM_W'(i_index) + fhp_pkg::DIM_W'(1);
                    n_state = fhp_pkg::S_IBW;
                end
            end
            fhp_pkg::S_IBW: begin
                n_state = fhp_pkg::S_IDLE;
            end
            fhp_pkg::S_MH: begin
                n_prod  = w_mul;
                n_state = fhp_pkg::S_ML;
            end
            fhp_pkg::S_ML: begin
                n_acc   = r_acc + (fhp_pkg::ACC_W'(r_prod) <<< fhp_pkg::LO_W);
                n_prod  = w_mul;
                n_state = fhp_pkg::S_AC;
            end
            fhp_pkg::S_AC: begin
                n_acc = r_acc + fhp_pkg::ACC_W'(r_prod);
                if (r_j == w_d - fhp_pkg::DIM_W'(1)) begin
                    n_state = fhp_pkg::S_WR;
                end else begin
                    n_j     = r_j + fhp_pkg::DIM_W'(1);
                    n_state = fhp_pkg::S_MH;
                end
            end
            fhp_pkg::S_WR: begin
                n_total = r_total + r_acc;
                n_acc   = '0;
                n_j     = '0;
                if (r_emit) begin
                    n_hrow[hidx] = fhp_pkg::sat_val(r_acc);
                end else begin
                    pp_we = 1'b1;
                end
                if (r_a == w_d) begin
                    n_state = fhp_pkg::S_WT;
                end else begin
                    n_a     = r_a + fhp_pkg::DIM_W'(1);
                    n_state = fhp_pkg::S_MH;
                end
            end
            fhp_pkg::S_WT: begin
                // Vertex 0 takes the negated exact sum, rounded once.
                n_total  = '0;
                n_a      = fhp_pkg::DIM_W'(1);
                pp_waddr = fhp_pkg::PP_AW'(r_i) * fhp_pkg::PP_AW'(fhp_pkg::NCOL)
                         + fhp_pkg::PP_AW'(r_c);
                pp_wdata = fhp_pkg::sat_pp(w_neg_total);
                if (r_emit) begin
                    n_hrow[fhp_pkg::HROW_W'(r_i)] = fhp_pkg::sat_val(w_neg_total);
                end else begin
                    pp_we = 1'b1;
                end
                if (r_i != w_d - fhp_pkg::DIM_W'(1)) begin
                    n_i     = r_i + fhp_pkg::DIM_W'(1);
                    n_state = fhp_pkg::S_MH;
                end else if (r_emit) begin
                    n_half  = 1'b0;
                    n_state = fhp_pkg::S_OUT;
                end else if (fhp_pkg::IDX_W'(r_c) ==
                             fhp_pkg::IDX_W'(w_d) * fhp_pkg::IDX_W'(w_d)
                             - fhp_pkg::IDX_W'(1)) begin
                    n_emit  = 1'b1;
                    n_r     = '0;
                    n_i     = '0;
                    n_state = fhp_pkg::S_MH;
                end else begin
                    n_state = fhp_pkg::S_IDLE;
                end
            end
            fhp_pkg::S_OUT: begin
                if (!r_out_valid) begin
                    n_out_valid = 1'b1;
                    n_out_row   = r_r;
                    n_out_half  = r_half;
                    n_out_last  = (r_r == w_n - fhp_pkg::HROW_W'(1))
                               && (r_half == w_two_halves);
                    for (int k = 0; k < fhp_pkg::HALF_N; k++) begin
                        n_out[k] = r_hrow[fhp_pkg::HROW_W'(r_half)
                                          * fhp_pkg::HROW_W'(fhp_pkg::HALF_N)
                                          + fhp_pkg::HROW_W'(k)];
                    end
                end else if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    if (w_two_halves && !r_half) begin
                        n_half = 1'b1;
                    end else if (r_r == w_n - fhp_pkg::HROW_W'(1)) begin
                        n_emit  = 1'b0;
                        n_state = fhp_pkg::S_IDLE;
                    end else begin
                        n_r     = r_r + fhp_pkg::HROW_W'(1);
                        n_i     = '0;
                        n_a     = fhp_pkg::DIM_W'(1);
                        n_j     = '0;
                        n_state = fhp_pkg::S_MH;
                    end
                end
            end
            default: begin
                n_state = fhp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fhp_pkg::S_IDLE;
            r_three_dim <= 1'b1;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
            r_i         <= '0;
            r_a         <= fhp_pkg::DIM_W'(1);
            r_j         <= '0;
            r_r         <= '0;
            r_half      <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) begin
                r_three_dim <= i_cfg_wdata;
            end
            r_emit      <= n_emit;
            r_out_valid <= n_out_valid;
            r_i         <= n_i;
            r_a         <= n_a;
            r_j         <= n_j;
            r_r         <= n_r;
            r_half      <= n_half;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c        <= n_c;
        r_v        <= n_v;
        r_prod     <= n_prod;
        r_acc      <= n_acc;
        r_total    <= n_total;
        r_hrow     <= n_hrow;
        r_out_row  <= n_out_row;
        r_out_half <= n_out_half;
        r_out_last <= n_out_last;
        r_out      <= n_out;
    end

    fhp_ram #(
        .W     (fhp_pkg::IB_W),
        .DEPTH (fhp_pkg::MAX_DIM)
    ) u_ib_ram (
        .i_clk   (i_clk),
        .i_we    (ib_we),
        .i_waddr (ib_waddr),
        .i_wdata (ib_wdata),
        .i_raddr (ib_raddr),
        .o_rdata (ib_rdata)
    );

    // Writes and reads of the partial products never overlap: columns are
    // written only while loading, and read only during emission.
    fhp_ram #(
        .W     (fhp_pkg::PP_W),
        .DEPTH (fhp_pkg::PP_DEPTH)
    ) u_pp_ram (
        .i_clk   (i_clk),
        .i_we    (pp_we),
        .i_waddr (pp_waddr),
        .i_wdata (pp_wdata),
        .i_raddr (pp_raddr),
        .o_rdata (pp_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_row       = 4'(r_out_row);
    assign o_half      = r_out_half;
    assign o_out_0     = r_out[0];
    assign o_out_1     = r_out[1];
    assign o_out_2     = r_out[2];
    assign o_out_3     = r_out[3];
    assign o_out_4     = r_out[4];
    assign o_out_5     = r_out[5];
    assign o_last      = r_out_last;

    // A held half-row keeps the input side closed.
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while a half-row is pending");

    // The final transfer of an element returns the block to idle.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last) |=> (!o_out_valid && !o_in_stall))
        else $error("block not idle after the final half-row");

    // A valid column load starts the sequencer.
    a_col_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_mode && col_ok) |=> (o_in_stall && !o_out_valid))
        else $error("column load did not start the sequencer");

    // Emitted rows stay inside the element's nodal Hessian.
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_out_row < w_n))
        else $error("row out of range");

endmodule
